// ===== rtl/cwmma_pkg.sv =====
// Shared constants, types and level helpers for the cascaded window statistics block.
package cwmma_pkg;

    // Ring depths
    localparam int MINUTE_SLOTS = 60;
    localparam int HOUR_SLOTS   = 60;
    localparam int DAY_SLOTS    = 24;

    localparam int SAMPLE_W    = 16;
    localparam int NUM_CHAN    = 2;
    localparam int TOTAL_SLOTS = MINUTE_SLOTS + HOUR_SLOTS + DAY_SLOTS;
    localparam int MAX_MH      = (MINUTE_SLOTS > HOUR_SLOTS) ? MINUTE_SLOTS : HOUR_SLOTS;
    localparam int MAX_SLOTS   = (MAX_MH > DAY_SLOTS) ? MAX_MH : DAY_SLOTS;

    localparam int ADDR_W     = $clog2(TOTAL_SLOTS);
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_SLOTS);
    localparam int DIV_STEP_W = $clog2(SUM_W);
    localparam int MIN_POS_W  = $clog2(MINUTE_SLOTS);
    localparam int HOUR_POS_W = $clog2(HOUR_SLOTS);
    localparam int DAY_POS_W  = $clog2(DAY_SLOTS);
    localparam int LEVEL_W    = 2;
    localparam int OUT_DATA_W = 6 * SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [LEVEL_W-1:0]         level_t;

    // Level codes
    localparam level_t LVL_MINUTE = 2'd0;
    localparam level_t LVL_HOUR   = 2'd1;
    localparam level_t LVL_DAY    = 2'd2;

    // Reset value of the missing-sample code, also read back for every unwritten store entry
    localparam sample_t NO_DATA_RESET = 16'sh8000;
    localparam sample_t SAMPLE_MAX    = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN    = 16'sh8000;

    // First store address of a level
    function automatic logic [ADDR_W-1:0] level_base(input level_t lvl);
        logic [ADDR_W-1:0] base;
        unique case (lvl)
            LVL_HOUR: base = ADDR_W'(MINUTE_SLOTS);
            LVL_DAY:  base = ADDR_W'(MINUTE_SLOTS + HOUR_SLOTS);
            default:  base = '0;
        endcase
        return base;
    endfunction

    // Index of the last slot of a level
    function automatic logic [IDX_W-1:0] level_last_idx(input level_t lvl);
        logic [IDX_W-1:0] last_idx;
        unique case (lvl)
            LVL_HOUR: last_idx = IDX_W'(HOUR_SLOTS - 1);
            LVL_DAY:  last_idx = IDX_W'(DAY_SLOTS - 1);
            default:  last_idx = IDX_W'(MINUTE_SLOTS - 1);
        endcase
        return last_idx;
    endfunction

endpackage

// ===== rtl/cascaded_window_min_max_avg.sv =====
// Top level: minute, hour and day ring statistics over one shared scan and divide datapath.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  tdata: humidity, temperature
//  m_        out  m_tvalid/m_tready  tdata: six stats; tuser: level, wrapped; tlast: day result
//  cfg_      in   cfg_wr_en          cfg_wr_data: no-data code
//
// Each sample gives three transfers, one per level. A level runs through one store
// write, one read per slot through the single store read port, a pipeline drain
// state and a divider setup state, SUM_W steps of the shared restoring divider,
// and an emit state. A stalled output holds the sequencer in the emit state.
// Reset clears the per-entry valid bits at once, so no clearing pass is needed;
// s_tready is high only while the sequencer is idle.
module cascaded_window_min_max_avg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // humidity [15:0], temperature [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // hum_avg, hum_min, hum_max, temp_avg, temp_min, temp_max
    output logic [2:0]  m_tuser,    // level [1:0], window_wrapped [2]
    output logic        m_tlast
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_WRITE  = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_PREP   = 7'b0010000,
        ST_DIVIDE = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    cwmma_pkg::level_t                  level_reg, level_next;
    logic [cwmma_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [cwmma_pkg::DIV_STEP_W-1:0]   step_reg, step_next;
    logic [cwmma_pkg::MIN_POS_W-1:0]    min_pos_reg, min_pos_next;
    logic [cwmma_pkg::HOUR_POS_W-1:0]   hour_pos_reg, hour_pos_next;
    logic [cwmma_pkg::DAY_POS_W-1:0]    day_pos_reg, day_pos_next;
    logic                               wrap_reg, wrap_next;
    cwmma_pkg::sample_t                 code_reg, code_next;
    cwmma_pkg::sample_t                 wr_hum_reg, wr_hum_next;
    cwmma_pkg::sample_t                 wr_temp_reg, wr_temp_next;
    logic [cwmma_pkg::TOTAL_SLOTS-1:0]  entry_vld_reg, entry_vld_next;
    logic                               rd_pipe_reg, rd_pipe_next;

    // Store: humidity in the low half, temperature in the high half
    logic [2*cwmma_pkg::SAMPLE_W-1:0]   store_mem [cwmma_pkg::TOTAL_SLOTS];
    logic [2*cwmma_pkg::SAMPLE_W-1:0]   rd_data_reg;
    logic                               rd_vld_reg;

    // Per-channel accumulators and divider
    logic signed [cwmma_pkg::SUM_W-1:0] sum_reg [cwmma_pkg::NUM_CHAN];
    logic signed [cwmma_pkg::SUM_W-1:0] sum_next [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::CNT_W-1:0]        cnt_reg [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::CNT_W-1:0]        cnt_next [cwmma_pkg::NUM_CHAN];
    cwmma_pkg::sample_t                 lo_reg [cwmma_pkg::NUM_CHAN];
    cwmma_pkg::sample_t                 lo_next [cwmma_pkg::NUM_CHAN];
    cwmma_pkg::sample_t                 hi_reg [cwmma_pkg::NUM_CHAN];
    cwmma_pkg::sample_t                 hi_next [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::SUM_W-1:0]        dq_reg [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::SUM_W-1:0]        dq_next [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::CNT_W-1:0]        rem_reg [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::CNT_W-1:0]        rem_next [cwmma_pkg::NUM_CHAN];
    logic                               neg_reg [cwmma_pkg::NUM_CHAN];
    logic                               neg_next [cwmma_pkg::NUM_CHAN];

    // Output register
    logic                               out_valid_reg, out_valid_next;
    cwmma_pkg::level_t                  out_level_reg, out_level_next;
    logic                               out_wrap_reg, out_wrap_next;
    logic                               out_last_reg, out_last_next;
    logic [cwmma_pkg::OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    // Datapath helpers
    cwmma_pkg::sample_t                 samp [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::CNT_W:0]          trial [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::SUM_W-1:0]        quot_signed [cwmma_pkg::NUM_CHAN];
    cwmma_pkg::sample_t                 stat_avg [cwmma_pkg::NUM_CHAN];
    cwmma_pkg::sample_t                 stat_min [cwmma_pkg::NUM_CHAN];
    cwmma_pkg::sample_t                 stat_max [cwmma_pkg::NUM_CHAN];
    logic [cwmma_pkg::ADDR_W-1:0]       wr_addr;
    logic [cwmma_pkg::ADDR_W-1:0]       rd_addr;
    logic [cwmma_pkg::ADDR_W-1:0]       pos_ext;
    logic                               out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_wrap_reg, out_level_reg};
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Select the write position of the current level
    always_comb begin
        unique case (level_reg)
            cwmma_pkg::LVL_HOUR: pos_ext = cwmma_pkg::ADDR_W'(hour_pos_reg);
            cwmma_pkg::LVL_DAY:  pos_ext = cwmma_pkg::ADDR_W'(day_pos_reg);
            default:             pos_ext = cwmma_pkg::ADDR_W'(min_pos_reg);
        endcase
    end

    assign wr_addr = cwmma_pkg::level_base(level_reg) + pos_ext;
    assign rd_addr = cwmma_pkg::level_base(level_reg) + cwmma_pkg::ADDR_W'(idx_reg);

    // Unwritten entries read as the reset code; finish the divide per channel
    always_comb begin
        for (int c = 0; c < cwmma_pkg::NUM_CHAN; c++) begin
            samp[c] = rd_vld_reg ? $signed(rd_data_reg[c*cwmma_pkg::SAMPLE_W +: cwmma_pkg::SAMPLE_W])
                                 : cwmma_pkg::NO_DATA_RESET;
            trial[c] = {rem_reg[c], dq_reg[c][cwmma_pkg::SUM_W-1]};
            quot_signed[c] = neg_reg[c] ? ('0 - dq_reg[c]) : dq_reg[c];
            if (cnt_reg[c] == '0) begin
                stat_avg[c] = code_reg;
                stat_min[c] = code_reg;
                stat_max[c] = code_reg;
            end else begin
                stat_avg[c] = $signed(quot_signed[c][cwmma_pkg::SAMPLE_W-1:0]);
                stat_min[c] = lo_reg[c];
                stat_max[c] = hi_reg[c];
            end
        end
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        min_pos_next   = min_pos_reg;
        hour_pos_next  = hour_pos_reg;
        day_pos_next   = day_pos_reg;
        wrap_next      = wrap_reg;
        code_next      = cfg_wr_en ? $signed(cfg_wr_data) : code_reg;
        wr_hum_next    = wr_hum_reg;
        wr_temp_next   = wr_temp_reg;
        entry_vld_next = entry_vld_reg;
        rd_pipe_next   = (state_reg == ST_SCAN);
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_level_next = out_level_reg;
        out_wrap_next  = out_wrap_reg;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;
        for (int c = 0; c < cwmma_pkg::NUM_CHAN; c++) begin
            sum_next[c] = sum_reg[c];
            cnt_next[c] = cnt_reg[c];
            lo_next[c]  = lo_reg[c];
            hi_next[c]  = hi_reg[c];
            dq_next[c]  = dq_reg[c];
            rem_next[c] = rem_reg[c];
            neg_next[c] = neg_reg[c];
            // Accumulate valid entries as they come out of the store
            if (rd_pipe_reg && (samp[c] != code_reg)) begin
                sum_next[c] = sum_reg[c] + cwmma_pkg::SUM_W'(samp[c]);
                cnt_next[c] = cnt_reg[c] + 1'b1;
                if (samp[c] < lo_reg[c]) begin
                    lo_next[c] = samp[c];
                end
                if (samp[c] > hi_reg[c]) begin
                    hi_next[c] = samp[c];
                end
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    wr_hum_next  = $signed(s_tdata[15:0]);
                    wr_temp_next = $signed(s_tdata[31:16]);
                    level_next   = cwmma_pkg::LVL_MINUTE;
                    state_next   = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // Write the current slot, then advance its position (hour and day only after a wrap below)
                entry_vld_next[wr_addr] = 1'b1;
                unique case (level_reg)
                    cwmma_pkg::LVL_HOUR: begin
                        wrap_next = 1'b0;
                        if (wrap_reg) begin
                            if (hour_pos_reg == cwmma_pkg::HOUR_POS_W'(cwmma_pkg::HOUR_SLOTS - 1)) begin
                                hour_pos_next = '0;
                                wrap_next     = 1'b1;
                            end else begin
                                hour_pos_next = hour_pos_reg + 1'b1;
                            end
                        end
                    end
                    cwmma_pkg::LVL_DAY: begin
                        wrap_next = 1'b0;
                        if (wrap_reg) begin
                            if (day_pos_reg == cwmma_pkg::DAY_POS_W'(cwmma_pkg::DAY_SLOTS - 1)) begin
                                day_pos_next = '0;
                                wrap_next    = 1'b1;
                            end else begin
                                day_pos_next = day_pos_reg + 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (min_pos_reg == cwmma_pkg::MIN_POS_W'(cwmma_pkg::MINUTE_SLOTS - 1)) begin
                            min_pos_next = '0;
                            wrap_next    = 1'b1;
                        end else begin
                            min_pos_next = min_pos_reg + 1'b1;
                            wrap_next    = 1'b0;
                        end
                    end
                endcase
                for (int c = 0; c < cwmma_pkg::NUM_CHAN; c++) begin
                    sum_next[c] = '0;
                    cnt_next[c] = '0;
                    lo_next[c]  = cwmma_pkg::SAMPLE_MAX;
                    hi_next[c]  = cwmma_pkg::SAMPLE_MIN;
                end
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // Issue one read a cycle over the level's slots
                if (idx_reg == cwmma_pkg::level_last_idx(level_reg)) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                // Load the divider with the magnitude of each sum
                for (int c = 0; c < cwmma_pkg::NUM_CHAN; c++) begin
                    neg_next[c] = sum_reg[c][cwmma_pkg::SUM_W-1];
                    dq_next[c]  = sum_reg[c][cwmma_pkg::SUM_W-1] ? ('0 - $unsigned(sum_reg[c]))
                                                                  : $unsigned(sum_reg[c]);
                    rem_next[c] = '0;
                end
                step_next  = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                // One restoring step per cycle, quotient shifts in at the bottom
                for (int c = 0; c < cwmma_pkg::NUM_CHAN; c++) begin
                    if (trial[c] >= {1'b0, cnt_reg[c]}) begin
                        rem_next[c] = cwmma_pkg::CNT_W'(trial[c] - {1'b0, cnt_reg[c]});
                        dq_next[c]  = {dq_reg[c][cwmma_pkg::SUM_W-2:0], 1'b1};
                    end else begin
                        rem_next[c] = cwmma_pkg::CNT_W'(trial[c]);
                        dq_next[c]  = {dq_reg[c][cwmma_pkg::SUM_W-2:0], 1'b0};
                    end
                end
                if (step_reg == cwmma_pkg::DIV_STEP_W'(cwmma_pkg::SUM_W - 1)) begin
                    state_next = ST_EMIT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free, then move to the next level, or to idle after the day level
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_level_next = level_reg;
                    out_wrap_next  = wrap_reg;
                    out_last_next  = (level_reg == cwmma_pkg::LVL_DAY);
                    out_data_next  = {stat_max[1], stat_min[1], stat_avg[1],
                                      stat_max[0], stat_min[0], stat_avg[0]};
                    wr_hum_next    = stat_avg[0];
                    wr_temp_next   = stat_avg[1];
                    idx_next       = '0;
                    if (level_reg == cwmma_pkg::LVL_DAY) begin
                        level_next = cwmma_pkg::LVL_MINUTE;
                        state_next = ST_IDLE;
                    end else begin
                        level_next = (level_reg == cwmma_pkg::LVL_MINUTE) ? cwmma_pkg::LVL_HOUR
                                                                          : cwmma_pkg::LVL_DAY;
                        state_next = ST_WRITE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            level_reg     <= cwmma_pkg::LVL_MINUTE;
            idx_reg       <= '0;
            step_reg      <= '0;
            min_pos_reg   <= '0;
            hour_pos_reg  <= '0;
            day_pos_reg   <= '0;
            wrap_reg      <= 1'b0;
            code_reg      <= cwmma_pkg::NO_DATA_RESET;
            entry_vld_reg <= '0;
            rd_pipe_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            min_pos_reg   <= min_pos_next;
            hour_pos_reg  <= hour_pos_next;
            day_pos_reg   <= day_pos_next;
            wrap_reg      <= wrap_next;
            code_reg      <= code_next;
            entry_vld_reg <= entry_vld_next;
            rd_pipe_reg   <= rd_pipe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        wr_hum_reg     <= wr_hum_next;
        wr_temp_reg    <= wr_temp_next;
        out_level_reg  <= out_level_next;
        out_wrap_reg   <= out_wrap_next;
        out_last_reg   <= out_last_next;
        out_data_reg   <= out_data_next;
        for (int c = 0; c < cwmma_pkg::NUM_CHAN; c++) begin
            sum_reg[c] <= sum_next[c];
            cnt_reg[c] <= cnt_next[c];
            lo_reg[c]  <= lo_next[c];
            hi_reg[c]  <= hi_next[c];
            dq_reg[c]  <= dq_next[c];
            rem_reg[c] <= rem_next[c];
            neg_reg[c] <= neg_next[c];
        end
    end

    // Sample store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            store_mem[wr_addr] <= {wr_temp_reg, wr_hum_reg};
        end
        rd_data_reg <= store_mem[rd_addr];
        rd_vld_reg  <= entry_vld_reg[rd_addr];
    end

endmodule
